// File: rtl/cmm_pkg.sv
// Shared types, constants and codes of the cost matrix mask and min block.
package cmm_pkg;

   localparam int CMM_MAX_NODES   = 32;
   localparam int CMM_VALUE_WIDTH = 16;

   // operation codes
   localparam logic [2:0] OP_WRITE    = 3'd0;
   localparam logic [2:0] OP_MASK_ROW = 3'd1;
   localparam logic [2:0] OP_MASK_COL = 3'd2;
   localparam logic [2:0] OP_REDUCE   = 3'd3;
   localparam logic [2:0] OP_ROW_MIN  = 3'd4;
   localparam logic [2:0] OP_COL_MIN  = 3'd5;
   // unused codes: no effect, no result
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // register map (word index taken from paddr[2])
   localparam int         CSR_ADDR_WIDTH   = 3;
   localparam logic       REG_NODE_COUNT   = 1'b0;
   localparam logic [5:0] NODE_COUNT_RESET = 6'd32;

   typedef struct packed {
      logic [2:0]         op;
      logic [4:0]         row_index;
      logic [4:0]         col_index;
      logic signed [15:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [14:0] min_value;
      logic        none_found;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MASK_ROW,
      ST_MASK_COL,
      ST_FIND,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// File: rtl/cmm_ram.sv
// Single-port-write, registered-read matrix store.
module cmm_ram #(
   parameter int DEPTH = cmm_pkg::CMM_MAX_NODES * cmm_pkg::CMM_MAX_NODES,
   parameter int WIDTH = cmm_pkg::CMM_VALUE_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/cmm_ctrl.sv
// Sequencer: line walks for mask and find, running minimum, result register.
module cmm_ctrl #(
   parameter int MAX_NODES   = cmm_pkg::CMM_MAX_NODES,
   parameter int VALUE_WIDTH = cmm_pkg::CMM_VALUE_WIDTH,
   parameter int AW          = $clog2(MAX_NODES * MAX_NODES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [5:0]             node_count,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cmm_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cmm_pkg::rsp_type       rsp_data,
   output logic                   mem_we,
   output logic [AW-1:0]          mem_waddr,
   output logic [VALUE_WIDTH-1:0] mem_wdata,
   output logic                   mem_re,
   output logic [AW-1:0]          mem_raddr,
   input  logic [VALUE_WIDTH-1:0] mem_rdata
);

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SW = $clog2(MAX_NODES + 1);
   localparam int NW = (SW > 6) ? SW : 6;
   localparam int CW = (SW > 5) ? SW : 5;
   localparam logic signed [32:0] VMAX = 33'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);

   cmm_pkg::state_type state_ff, state_in;

   logic [SW-1:0]          t_ff, t_in;
   logic [IW-1:0]          row_ff, col_ff;
   logic                   reduce_ff, col_ok_ff, along_row_ff;
   logic                   found_ff, rd_pend_ff;
   logic [VALUE_WIDTH-1:0] best_ff;
   logic                   rsp_valid_ff;
   cmm_pkg::rsp_type       rsp_data_ff;

   logic [SW-1:0]     side;
   logic              accept, row_ok, col_ok, last, out_free;
   logic signed [32:0] ev, ev_sat;

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
      return AW'(AW'(r) * AW'(MAX_NODES)) + AW'(c);
   endfunction

   // side in use: node_count clipped to MAX_NODES
   always_comb begin
      if (NW'(node_count) > NW'(MAX_NODES)) begin
         side = SW'(MAX_NODES);
      end else begin
         side = SW'(node_count);
      end
   end

   assign accept   = req_valid && !req_stall;
   assign row_ok   = CW'(req_data.row_index) < CW'(side);
   assign col_ok   = CW'(req_data.col_index) < CW'(side);
   assign last     = SW'(t_ff + 1'b1) == side;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // write value clamp to [-1, largest positive]
   always_comb begin
      ev = 33'($signed(req_data.entry_value));
      if (ev < -33'sd1) begin
         ev_sat = -33'sd1;
      end else if (ev > VMAX) begin
         ev_sat = VMAX;
      end else begin
         ev_sat = ev;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cmm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  cmm_pkg::OP_MASK_ROW: begin
                     state_in = row_ok ? cmm_pkg::ST_MASK_ROW : cmm_pkg::ST_IDLE;
                  end
                  cmm_pkg::OP_MASK_COL: begin
                     state_in = col_ok ? cmm_pkg::ST_MASK_COL : cmm_pkg::ST_IDLE;
                  end
                  cmm_pkg::OP_REDUCE: begin
                     if (row_ok) begin
                        state_in = cmm_pkg::ST_MASK_ROW;
                     end else if (col_ok) begin
                        state_in = cmm_pkg::ST_MASK_COL;
                     end else begin
                        state_in = cmm_pkg::ST_IDLE;
                     end
                  end
                  cmm_pkg::OP_ROW_MIN: begin
                     state_in = row_ok ? cmm_pkg::ST_FIND : cmm_pkg::ST_DONE;
                  end
                  cmm_pkg::OP_COL_MIN: begin
                     state_in = col_ok ? cmm_pkg::ST_FIND : cmm_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = cmm_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         cmm_pkg::ST_MASK_ROW: begin
            if (last) begin
               state_in = (reduce_ff && col_ok_ff) ? cmm_pkg::ST_MASK_COL : cmm_pkg::ST_IDLE;
            end
         end
         cmm_pkg::ST_MASK_COL: begin
            if (last) begin
               state_in = cmm_pkg::ST_IDLE;
            end
         end
         cmm_pkg::ST_FIND: begin
            if (last) begin
               state_in = cmm_pkg::ST_DRAIN;
            end
         end
         cmm_pkg::ST_DRAIN: begin
            state_in = cmm_pkg::ST_DONE;
         end
         cmm_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = cmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs to the store and the handshake
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = addr_of(IW'(req_data.row_index), IW'(req_data.col_index));
      mem_wdata = '1;
      mem_re    = 1'b0;
      mem_raddr = along_row_ff ? addr_of(row_ff, t_ff[IW-1:0]) : addr_of(t_ff[IW-1:0], col_ff);
      t_in      = SW'(t_ff + 1'b1);
      unique case (state_ff)
         cmm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            mem_we    = accept && (req_data.op == cmm_pkg::OP_WRITE) && row_ok && col_ok;
            mem_wdata = ev_sat[VALUE_WIDTH-1:0];
            t_in      = '0;
         end
         cmm_pkg::ST_MASK_ROW: begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(row_ff, t_ff[IW-1:0]);
         end
         cmm_pkg::ST_MASK_COL: begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(t_ff[IW-1:0], col_ff);
         end
         cmm_pkg::ST_FIND: begin
            mem_re = 1'b1;
         end
         default: begin
            t_in = '0;
         end
      endcase
      if (last) begin
         t_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmm_pkg::ST_IDLE;
         t_ff         <= '0;
         found_ff     <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         t_ff       <= t_in;
         rd_pend_ff <= mem_re;
         if (state_ff == cmm_pkg::ST_IDLE && accept) begin
            found_ff <= 1'b0;
         end else if (rd_pend_ff && !mem_rdata[VALUE_WIDTH-1]
                      && (!found_ff || mem_rdata < best_ff)) begin
            found_ff <= 1'b1;
         end
         if (state_ff == cmm_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == cmm_pkg::ST_IDLE && accept) begin
         row_ff       <= IW'(req_data.row_index);
         col_ff       <= IW'(req_data.col_index);
         reduce_ff    <= req_data.op == cmm_pkg::OP_REDUCE;
         col_ok_ff    <= col_ok;
         along_row_ff <= req_data.op == cmm_pkg::OP_ROW_MIN;
      end
      if (rd_pend_ff && !mem_rdata[VALUE_WIDTH-1] && (!found_ff || mem_rdata < best_ff)) begin
         best_ff <= mem_rdata;
      end
      if (state_ff == cmm_pkg::ST_DONE && out_free) begin
         rsp_data_ff.min_value  <= found_ff ? 15'(best_ff) : 15'd0;
         rsp_data_ff.none_found <= !found_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/cost_matrix_mask_and_min_top.sv
// Top level of the cost matrix mask and min block: register port, sequencer, store.
//
// Square cost matrix for a branch-and-bound tour search, held in one
// synchronous RAM of MAX_NODES*MAX_NODES entries, entry (r, c) at address
// r*MAX_NODES + c, -1 meaning masked. With n the side in use (node_count
// clipped to MAX_NODES): a write entry goes straight to the RAM; mask row
// and mask column walk the n entries of the line through the RAM write
// port, one entry a cycle, and the next transfer is taken once the walk is
// done; reduce arc is a row walk then a column walk (a line outside the
// side in use is skipped); row and column min issue n reads, one a cycle,
// then wait for the last read data and load the result register (a line
// outside the side in use skips the reads), and the next transfer is taken
// after the load, later while an earlier result still sits stalled in the
// output register. One item is worked on at a time; a result waiting
// in the output register does not hold off new items, only a second
// result. The store has no reset: read only entries written since power
// up. node_count sits at byte address 0 of the APB port, reset 32.
module cost_matrix_mask_and_min_top #(
   parameter int MAX_NODES   = cmm_pkg::CMM_MAX_NODES,
   parameter int VALUE_WIDTH = cmm_pkg::CMM_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // item channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cmm_pkg::req_type                    req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cmm_pkg::rsp_type                    rsp_data,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cmm_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int AW    = $clog2(DEPTH);

   logic [5:0]             node_count_ff;
   logic                   mem_we, mem_re;
   logic [AW-1:0]          mem_waddr, mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

   // register port: word index is paddr[2], byte lanes ignored
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= cmm_pkg::NODE_COUNT_RESET;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == cmm_pkg::REG_NODE_COUNT) begin
         node_count_ff <= pwdata[5:0];
      end
   end

   always_comb begin
      if (paddr[2] == cmm_pkg::REG_NODE_COUNT) begin
         prdata = {26'd0, node_count_ff};
      end else begin
         prdata = '0;
      end
   end

   cmm_ctrl #(
      .MAX_NODES   (MAX_NODES),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // matrix store; the sequencer never overlaps a write and a read of one line
   cmm_ram #(
      .DEPTH (DEPTH),
      .WIDTH (VALUE_WIDTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

// File: rtl/cmm_checker.sv
// Port-level checks of the cost matrix mask and min block, with its bind.
module cmm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input cmm_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cmm_pkg::rsp_type rsp_data
);

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // empty line reports zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.none_found |-> rsp_data.min_value == 15'd0)
      else $error("none_found with non-zero min_value");

   // a find stalls the input in the cycle after it is taken
   a_find_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_data.op == cmm_pkg::OP_ROW_MIN || req_data.op == cmm_pkg::OP_COL_MIN)
      |=> req_stall)
      else $error("input taken straight after a find");

   // writes and unused codes leave the input open
   a_write_open: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_data.op == cmm_pkg::OP_WRITE || req_data.op == cmm_pkg::OP_SPARE_LO
                   || req_data.op == cmm_pkg::OP_SPARE_HI)
      |=> !req_stall)
      else $error("input stalled after a single-cycle op");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cost_matrix_mask_and_min_top cmm_checker u_cmm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
